// File: rtl/ps2ca_pkg.sv
// Shared types and constants for the PS/2 command acknowledge sequencer.
// Used by ps2ca_step and ps2_command_ack_sequencer; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ps2ca_pkg;

    localparam int TIMER_BITS = 24;
    localparam int CFG_BITS   = 24;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CMD_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_RST_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_READ_TIMEOUT = 2'd2;

    // Action codes of an input beat.
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_SEND     = 3'd1;
    localparam logic [2:0] ACT_RESET    = 3'd2;
    localparam logic [2:0] ACT_IDENTIFY = 3'd3;
    localparam logic [2:0] ACT_RX_BYTE  = 3'd4;

    // Job status codes.
    localparam logic [2:0] ST_ACKED      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT    = 3'd1;
    localparam logic [2:0] ST_UNEXPECTED = 3'd2;
    localparam logic [2:0] ST_RESET_OK   = 3'd3;
    localparam logic [2:0] ST_RESET_FAIL = 3'd4;
    localparam logic [2:0] ST_TYPE_OK    = 3'd5;
    localparam logic [2:0] ST_ID_FAIL    = 3'd6;

    // Device and host bytes.
    localparam logic [7:0] B_ACK       = 8'hFA;
    localparam logic [7:0] B_RESEND    = 8'hFE;
    localparam logic [7:0] B_ERROR     = 8'hFF;
    localparam logic [7:0] B_OVERRUN   = 8'h00;
    localparam logic [7:0] B_BAT_OK    = 8'hAA;
    localparam logic [7:0] B_BAT_FAIL1 = 8'hFC;
    localparam logic [7:0] B_BAT_FAIL2 = 8'hFD;
    localparam logic [7:0] B_ID_FIRST  = 8'hAB;
    localparam logic [7:0] B_RESET_CMD = 8'hFF;
    localparam logic [7:0] B_DISABLE   = 8'hF5;
    localparam logic [7:0] B_IDENTIFY  = 8'hF2;
    localparam logic [7:0] B_ENABLE    = 8'hF4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD,
        PH_RST,
        PH_RST_AA,
        PH_F5,
        PH_F2,
        PH_AB,
        PH_TYPE,
        PH_F4
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [7:0]              pending_byte;
        logic                    job_port;
        logic [TIMER_BITS-1:0]   ticks_left;
        logic [7:0]              held_result;
        logic [2:0]              held_status;
    } state_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_port;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] result_byte;
    } result_t;

    // A deadline of zero behaves as one tick.
    function automatic logic [TIMER_BITS-1:0] load_timer(input logic [CFG_BITS-1:0] v);
        logic [TIMER_BITS-1:0] t;
        t = TIMER_BITS'(v);
        if (CFG_BITS > TIMER_BITS && (v >> TIMER_BITS) != '0)
        begin
            t = '1;
        end
        if (t == '0)
        begin
            t = TIMER_BITS'(1);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ps2ca_step.sv
// Next-state and result logic for one input beat of the PS/2 sequencer.
// Depends on ps2ca_pkg for the state, result types and byte constants.
`timescale 1ns / 1ps
`default_nettype none

module ps2ca_step (
    input  ps2ca_pkg::state_t                cur,
    input  logic [2:0]                       action,
    input  logic                             port,
    input  logic [7:0]                       data_byte,
    input  logic [ps2ca_pkg::CFG_BITS-1:0]   cmd_timeout,
    input  logic [ps2ca_pkg::CFG_BITS-1:0]   rst_timeout,
    input  logic [ps2ca_pkg::CFG_BITS-1:0]   read_timeout,
    output ps2ca_pkg::state_t                nxt,
    output logic                             res_valid,
    output ps2ca_pkg::result_t               res
);
    import ps2ca_pkg::*;

    logic is_ack;
    logic is_resend;
    logic is_ignore;
    logic in_ack_wait;

    assign is_ack    = (data_byte == B_ACK);
    assign is_resend = (data_byte == B_RESEND) || (data_byte == B_ERROR)
                    || (data_byte == B_OVERRUN);
    // Power-on replies count as ordinary replies when the awaited byte is the reset command.
    assign is_ignore = ((data_byte == B_BAT_OK) || (data_byte == B_BAT_FAIL1)
                    || (data_byte == B_BAT_FAIL2)) && (cur.pending_byte != B_RESET_CMD);
    assign in_ack_wait = (cur.phase == PH_CMD) || (cur.phase == PH_RST) || (cur.phase == PH_F5)
                      || (cur.phase == PH_F2) || (cur.phase == PH_F4);

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;

        case (action)
            ACT_TICK:
            begin
                if (cur.phase != PH_IDLE && cur.phase != PH_RST_AA)
                begin
                    if (cur.ticks_left > TIMER_BITS'(1))
                    begin
                        nxt.ticks_left = cur.ticks_left - TIMER_BITS'(1);
                    end
                    else
                    begin
                        nxt.ticks_left = '0;
                        case (cur.phase)
                            PH_CMD:
                            begin
                                res_valid = 1'b1; res.done_res = 1'b1; res.status = ST_TIMEOUT;
                            end
                            PH_RST:
                            begin
                                res_valid = 1'b1; res.done_res = 1'b1;
                                res.status = ST_RESET_FAIL;
                            end
                            PH_F5:
                            begin
                                res_valid = 1'b1; res.done_res = 1'b1; res.status = ST_ID_FAIL;
                            end
                            PH_F2, PH_AB, PH_TYPE:
                            begin
                                nxt.held_status  = ST_ID_FAIL;
                                nxt.held_result  = '0;
                                nxt.phase        = PH_F4;
                                nxt.pending_byte = B_ENABLE;
                                nxt.ticks_left   = load_timer(cmd_timeout);
                                res_valid = 1'b1; res.tx_valid = 1'b1; res.tx_byte = B_ENABLE;
                            end
                            PH_F4:
                            begin
                                res_valid = 1'b1; res.done_res = 1'b1;
                                res.status = cur.held_status; res.result_byte = cur.held_result;
                            end
                            default:
                            begin
                                res_valid = 1'b0;
                            end
                        endcase
                    end
                end
            end

            ACT_SEND, ACT_RESET, ACT_IDENTIFY:
            begin
                if (cur.phase == PH_IDLE)
                begin
                    nxt.job_port    = port;
                    nxt.held_status = ST_ACKED;
                    nxt.held_result = '0;
                    res_valid       = 1'b1;
                    res.tx_valid    = 1'b1;
                    if (action == ACT_SEND)
                    begin
                        nxt.phase        = PH_CMD;
                        nxt.pending_byte = data_byte;
                        nxt.ticks_left   = load_timer(cmd_timeout);
                    end
                    else if (action == ACT_RESET)
                    begin
                        nxt.phase        = PH_RST;
                        nxt.pending_byte = B_RESET_CMD;
                        nxt.ticks_left   = load_timer(rst_timeout);
                    end
                    else
                    begin
                        nxt.phase        = PH_F5;
                        nxt.pending_byte = B_DISABLE;
                        nxt.ticks_left   = load_timer(cmd_timeout);
                    end
                    res.tx_byte = nxt.pending_byte;
                end
            end

            ACT_RX_BYTE:
            begin
                if (cur.phase == PH_RST_AA)
                begin
                    res_valid = 1'b1; res.done_res = 1'b1;
                    res.status = is_ack ? ST_RESET_OK : ST_RESET_FAIL;
                    res.result_byte = data_byte;
                end
                else if (cur.phase == PH_AB && data_byte == B_ID_FIRST)
                begin
                    nxt.phase      = PH_TYPE;
                    nxt.ticks_left = load_timer(read_timeout);
                end
                else if (cur.phase == PH_AB || cur.phase == PH_TYPE)
                begin
                    nxt.held_status  = (cur.phase == PH_TYPE) ? ST_TYPE_OK : ST_ID_FAIL;
                    nxt.held_result  = data_byte;
                    nxt.phase        = PH_F4;
                    nxt.pending_byte = B_ENABLE;
                    nxt.ticks_left   = load_timer(cmd_timeout);
                    res_valid = 1'b1; res.tx_valid = 1'b1; res.tx_byte = B_ENABLE;
                end
                else if (in_ack_wait && !is_ignore)
                begin
                    res_valid = 1'b1;
                    if (is_resend)
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = cur.pending_byte;
                    end
                    else
                    begin
                        case (cur.phase)
                            PH_CMD:
                            begin
                                res.done_res = 1'b1;
                                res.status = is_ack ? ST_ACKED : ST_UNEXPECTED;
                                res.result_byte = data_byte;
                            end
                            PH_RST:
                            begin
                                if (!is_ack && data_byte == B_BAT_OK)
                                begin
                                    // Self-test passed; the acknowledge may still follow.
                                    res_valid = 1'b0;
                                    nxt.phase = PH_RST_AA;
                                end
                                else
                                begin
                                    res.done_res = 1'b1;
                                    res.status = is_ack ? ST_RESET_OK : ST_RESET_FAIL;
                                    res.result_byte = data_byte;
                                end
                            end
                            PH_F5:
                            begin
                                if (is_ack)
                                begin
                                    nxt.phase        = PH_F2;
                                    nxt.pending_byte = B_IDENTIFY;
                                    nxt.ticks_left   = load_timer(cmd_timeout);
                                    res.tx_valid = 1'b1; res.tx_byte = B_IDENTIFY;
                                end
                                else
                                begin
                                    res.done_res = 1'b1; res.status = ST_ID_FAIL;
                                    res.result_byte = data_byte;
                                end
                            end
                            PH_F2:
                            begin
                                if (is_ack)
                                begin
                                    res_valid      = 1'b0;
                                    nxt.phase      = PH_AB;
                                    nxt.ticks_left = load_timer(read_timeout);
                                end
                                else
                                begin
                                    nxt.held_status  = ST_ID_FAIL;
                                    nxt.held_result  = data_byte;
                                    nxt.phase        = PH_F4;
                                    nxt.pending_byte = B_ENABLE;
                                    nxt.ticks_left   = load_timer(cmd_timeout);
                                    res.tx_valid = 1'b1; res.tx_byte = B_ENABLE;
                                end
                            end
                            default:
                            begin
                                res.done_res = 1'b1;
                                res.status = cur.held_status; res.result_byte = cur.held_result;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        res.tx_port = nxt.job_port;
        if (res_valid && res.done_res)
        begin
            nxt.phase = PH_IDLE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ps2_command_ack_sequencer.sv
// Top level of the PS/2 command acknowledge sequencer: state, configuration and result register.
// Depends on ps2ca_pkg and ps2ca_step.
`timescale 1ns / 1ps
`default_nettype none

// Runs one PS/2 host job at a time (send a command, reset the device, identify the device)
// and reports the bytes to transmit and the job outcome. Each input beat (a tick, a job
// request or a received byte) is accepted and its result, if any, appears in the output
// register on the next cycle, so the block sustains one item per clock; the input stalls
// only while a result beat sits in the output register and the output side stalls it. Beats
// that cause no result (ignored requests, countdown ticks) produce no output beat. The user
// must write timeout registers through the cfg port while the block is idle (not enforced).
module ps2_command_ack_sequencer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [ps2ca_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [2:0]                      action,
    input  wire logic                            port,
    input  wire logic [7:0]                      data_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 tx_valid,
    output logic [7:0]                           tx_byte,
    output logic                                 tx_port,
    output logic                                 done_res,
    output logic [2:0]                           status,
    output logic [7:0]                           result_byte
);
    import ps2ca_pkg::*;

    logic [CFG_BITS-1:0] cmd_timeout_reg;
    logic [CFG_BITS-1:0] rst_timeout_reg;
    logic [CFG_BITS-1:0] read_timeout_reg;
    state_t              state_reg;
    state_t              state_next;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                res_valid;
    result_t             res;
    logic                in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    ps2ca_step u_step (
        .cur          (state_reg),
        .action       (action),
        .port         (port),
        .data_byte    (data_byte),
        .cmd_timeout  (cmd_timeout_reg),
        .rst_timeout  (rst_timeout_reg),
        .read_timeout (read_timeout_reg),
        .nxt          (state_next),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_timeout_reg  <= CFG_BITS'(1000);
            rst_timeout_reg  <= CFG_BITS'(100);
            read_timeout_reg <= CFG_BITS'(10);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_CMD_TIMEOUT:  cmd_timeout_reg  <= cfg_wdata;
                CFG_RST_TIMEOUT:  rst_timeout_reg  <= cfg_wdata;
                CFG_READ_TIMEOUT: read_timeout_reg <= cfg_wdata;
                default:          cmd_timeout_reg  <= cmd_timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_IDLE, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (in_accept && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_valid    = out_reg.tx_valid;
    assign tx_byte     = out_reg.tx_byte;
    assign tx_port     = out_reg.tx_port;
    assign done_res    = out_reg.done_res;
    assign status      = out_reg.status;
    assign result_byte = out_reg.result_byte;

    a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !tx_valid)
        else $error("finished job also requests a transmit");

    a_open_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (status == ST_ACKED && result_byte == 8'h00))
        else $error("status or result byte set on a beat that ends no job");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid && res.done_res) |=> (state_reg.phase == PH_IDLE))
        else $error("sequencer not idle after a job ended");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

// File: bench/ps2_command_ack_sequencer_tb.sv
// Self-checking bench for ps2_command_ack_sequencer: directed job sequences, then random jobs
// under random input gaps and output stalls, compared against an in-bench job model.
// Depends on ps2ca_pkg and the RTL of the sequencer; reads no files.
`timescale 1ns / 1ps

module ps2_command_ack_sequencer_tb;

    import ps2ca_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;
    // Action codes past the defined set; the block must ignore them.
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [CFG_BITS-1:0] DEADLINE_MAX = '1;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_addr = CFG_CMD_TIMEOUT;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [2:0]          action = ACT_TICK;
    logic                port = 1'b0;
    logic [7:0]          data_byte = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic                tx_port;
    logic                done_res;
    logic [2:0]          status;
    logic [7:0]          result_byte;

    // Job model state and its copy of the timeout registers.
    phase_t                job_phase = PH_IDLE;
    logic [7:0]            awaited_byte = 8'h00;
    logic                  active_port = 1'b0;
    logic [TIMER_BITS-1:0] ticks_left = '0;
    logic [7:0]            held_byte = 8'h00;
    logic [2:0]            held_code = 3'd0;
    logic [CFG_BITS-1:0]   cmd_deadline = CFG_BITS'(1000);
    logic [CFG_BITS-1:0]   reset_deadline = CFG_BITS'(100);
    logic [CFG_BITS-1:0]   read_deadline = CFG_BITS'(10);

    result_t job_reports_q[$];

    bit idling = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int settings_used = 1;
    int outcome_count [0:7];

    ps2_command_ack_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .port        (port),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .tx_port     (tx_port),
        .done_res    (done_res),
        .status      (status),
        .result_byte (result_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- job model

    function automatic logic [TIMER_BITS-1:0] job_deadline(input logic [CFG_BITS-1:0] v);
        return (v == '0) ? TIMER_BITS'(1) : TIMER_BITS'(v);
    endfunction

    function automatic void post_report(input logic txv, input logic [7:0] txb,
                                        input logic done, input logic [2:0] code,
                                        input logic [7:0] rb);
        result_t r;
        r.tx_valid    = txv;
        r.tx_byte     = txb;
        r.tx_port     = active_port;
        r.done_res    = done;
        r.status      = code;
        r.result_byte = rb;
        job_reports_q.push_back(r);
        if (done)
        begin
            job_phase = PH_IDLE;
        end
    endfunction

    function automatic void transmit(input phase_t next, input logic [7:0] b,
                                     input logic [CFG_BITS-1:0] limit);
        job_phase = next;
        awaited_byte = b;
        ticks_left = job_deadline(limit);
        post_report(1'b1, b, 1'b0, 3'd0, 8'h00);
    endfunction

    // Identify re-enables scanning once 0xF5 is acknowledged; the outcome is held until 0xF4 settles.
    function automatic void reenable_scan(input logic [2:0] code, input logic [7:0] rb);
        held_code = code;
        held_byte = rb;
        transmit(PH_F4, B_ENABLE, cmd_deadline);
    endfunction

    function automatic void advance_job(input logic [2:0] act, input logic prt,
                                        input logic [7:0] b);
        bit is_ack;
        bit is_resend;
        bit is_power_on;
        is_ack = (b == B_ACK);
        is_resend = (b == B_RESEND) || (b == B_ERROR) || (b == B_OVERRUN);
        is_power_on = (b == B_BAT_OK) || (b == B_BAT_FAIL1) || (b == B_BAT_FAIL2);
        case (act)
            ACT_TICK:
            begin
                // The byte after 0xAA during a reset is awaited with no deadline.
                if (job_phase != PH_IDLE && job_phase != PH_RST_AA)
                begin
                    if (ticks_left > 1)
                    begin
                        ticks_left = ticks_left - 1'b1;
                    end
                    else
                    begin
                        ticks_left = '0;
                        case (job_phase)
                            PH_CMD:  post_report(1'b0, 8'h00, 1'b1, ST_TIMEOUT, 8'h00);
                            PH_RST:  post_report(1'b0, 8'h00, 1'b1, ST_RESET_FAIL, 8'h00);
                            PH_F5:   post_report(1'b0, 8'h00, 1'b1, ST_ID_FAIL, 8'h00);
                            PH_F2, PH_AB, PH_TYPE: reenable_scan(ST_ID_FAIL, 8'h00);
                            default: post_report(1'b0, 8'h00, 1'b1, held_code, held_byte);
                        endcase
                    end
                end
            end
            ACT_SEND, ACT_RESET, ACT_IDENTIFY:
            begin
                if (job_phase == PH_IDLE)
                begin
                    active_port = prt;
                    held_code = 3'd0;
                    held_byte = 8'h00;
                    if (act == ACT_SEND)
                    begin
                        transmit(PH_CMD, b, cmd_deadline);
                    end
                    else if (act == ACT_RESET)
                    begin
                        transmit(PH_RST, B_RESET_CMD, reset_deadline);
                    end
                    else
                    begin
                        transmit(PH_F5, B_DISABLE, cmd_deadline);
                    end
                end
            end
            ACT_RX_BYTE:
            begin
                if (job_phase == PH_RST_AA)
                begin
                    post_report(1'b0, 8'h00, 1'b1, is_ack ? ST_RESET_OK : ST_RESET_FAIL, b);
                end
                else if (job_phase == PH_AB)
                begin
                    if (b == B_ID_FIRST)
                    begin
                        job_phase = PH_TYPE;
                        ticks_left = job_deadline(read_deadline);
                    end
                    else
                    begin
                        reenable_scan(ST_ID_FAIL, b);
                    end
                end
                else if (job_phase == PH_TYPE)
                begin
                    reenable_scan(ST_TYPE_OK, b);
                end
                else if (job_phase != PH_IDLE)
                begin
                    // Power-on replies only count when the awaited byte is the reset command.
                    if (is_resend)
                    begin
                        post_report(1'b1, awaited_byte, 1'b0, 3'd0, 8'h00);
                    end
                    else if (!is_power_on || awaited_byte == B_RESET_CMD)
                    begin
                        case (job_phase)
                            PH_CMD:
                            begin
                                post_report(1'b0, 8'h00, 1'b1,
                                            is_ack ? ST_ACKED : ST_UNEXPECTED, b);
                            end
                            PH_RST:
                            begin
                                if (is_ack)
                                begin
                                    post_report(1'b0, 8'h00, 1'b1, ST_RESET_OK, b);
                                end
                                else if (b == B_BAT_OK)
                                begin
                                    job_phase = PH_RST_AA;
                                end
                                else
                                begin
                                    post_report(1'b0, 8'h00, 1'b1, ST_RESET_FAIL, b);
                                end
                            end
                            PH_F5:
                            begin
                                if (is_ack)
                                begin
                                    transmit(PH_F2, B_IDENTIFY, cmd_deadline);
                                end
                                else
                                begin
                                    post_report(1'b0, 8'h00, 1'b1, ST_ID_FAIL, b);
                                end
                            end
                            PH_F2:
                            begin
                                if (is_ack)
                                begin
                                    job_phase = PH_AB;
                                    ticks_left = job_deadline(read_deadline);
                                end
                                else
                                begin
                                    reenable_scan(ST_ID_FAIL, b);
                                end
                            end
                            default:
                            begin
                                post_report(1'b0, 8'h00, 1'b1, held_code, held_byte);
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                // Spare action codes leave the job untouched.
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input logic [2:0] act, input logic prt, input logic [7:0] b);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        port <= prt;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        advance_job(act, prt, b);
        items_sent++;
    endtask

    // Wait until every predicted beat has come out, then let beats that produce nothing
    // drain as well.
    task automatic settle();
        in_valid <= 1'b0;
        while (job_reports_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_timeouts(input logic [CFG_BITS-1:0] cmd_t, rst_t, read_t);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_CMD_TIMEOUT;
        cfg_wdata <= cmd_t;
        @(posedge clk);
        cmd_deadline = cmd_t;
        cfg_addr <= CFG_RST_TIMEOUT;
        cfg_wdata <= rst_t;
        @(posedge clk);
        reset_deadline = rst_t;
        cfg_addr <= CFG_READ_TIMEOUT;
        cfg_wdata <= read_t;
        @(posedge clk);
        read_deadline = read_t;
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (!idling)
        begin
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 5);
        end
        out_stall <= (stall_left > 0);
    end

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (job_reports_q.size() == 0)
            begin
                $error("result beat arrived with no report predicted");
                mismatches++;
            end
            else
            begin
                want = job_reports_q.pop_front();
                check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
                check_field("tx_byte", want.tx_byte, tx_byte);
                check_field("tx_port", 8'(want.tx_port), 8'(tx_port));
                check_field("done_res", 8'(want.done_res), 8'(done_res));
                check_field("status", 8'(want.status), 8'(status));
                check_field("result_byte", want.result_byte, result_byte);
                if (want.done_res)
                begin
                    outcome_count[want.status]++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_command_job();
        send_item(ACT_TICK, 1'b0, 8'h00);
        send_item(ACT_RX_BYTE, 1'b1, B_ACK);
        send_item(ACT_SPARE_HI, 1'b1, 8'hFF);
        // Sending 0xFF makes power-on replies unexpected.
        send_item(ACT_SEND, 1'b1, 8'hFF);
        send_item(ACT_RX_BYTE, 1'b0, B_RESEND);
        send_item(ACT_RX_BYTE, 1'b0, B_BAT_OK);
        send_item(ACT_SEND, 1'b0, 8'h00);
        send_item(ACT_RESET, 1'b1, 8'h00);
        send_item(ACT_RX_BYTE, 1'b0, B_BAT_FAIL1);
        send_item(ACT_RX_BYTE, 1'b1, B_ACK);
    endtask

    task automatic test_reset_job();
        send_item(ACT_RESET, 1'b0, 8'h00);
        send_item(ACT_RX_BYTE, 1'b0, B_BAT_OK);
        send_item(ACT_TICK, 1'b0, 8'h00);
        send_item(ACT_RX_BYTE, 1'b0, B_ACK);
        send_item(ACT_RESET, 1'b1, 8'h7E);
        send_item(ACT_RX_BYTE, 1'b0, B_BAT_FAIL2);
    endtask

    task automatic test_identify_job();
        send_item(ACT_IDENTIFY, 1'b1, 8'h00);
        send_item(ACT_RX_BYTE, 1'b0, B_ACK);
        send_item(ACT_RX_BYTE, 1'b0, B_OVERRUN);
        send_item(ACT_RX_BYTE, 1'b0, B_ACK);
        send_item(ACT_RX_BYTE, 1'b0, B_ID_FIRST);
        send_item(ACT_RX_BYTE, 1'b0, 8'h80);
        send_item(ACT_RX_BYTE, 1'b0, B_ACK);
    endtask

    // Zero in every timeout register behaves as a single tick.
    task automatic test_deadlines();
        settle();
        load_timeouts('0, '0, '0);
        send_item(ACT_SEND, 1'b1, 8'h42);
        send_item(ACT_TICK, 1'b0, 8'h00);
        send_item(ACT_RESET, 1'b0, 8'h00);
        send_item(ACT_TICK, 1'b1, 8'h00);
        send_item(ACT_IDENTIFY, 1'b1, 8'h00);
        send_item(ACT_RX_BYTE, 1'b0, B_ACK);
        send_item(ACT_RX_BYTE, 1'b0, B_ACK);
        send_item(ACT_TICK, 1'b0, 8'h00);
        send_item(ACT_TICK, 1'b0, 8'h00);
    endtask

    function automatic logic [7:0] pick_reply(input bit settle_job);
        int roll;
        roll = $urandom_range(0, 99);
        if (job_phase == PH_TYPE)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (job_phase == PH_AB)
        begin
            return (settle_job || roll < 75) ? B_ID_FIRST : 8'($urandom_range(0, 255));
        end
        if (job_phase == PH_RST_AA)
        begin
            if (roll < 50)
                return B_ACK;
            else if (roll < 75)
                return ($urandom_range(0, 1) != 0) ? B_BAT_FAIL1 : B_BAT_FAIL2;
            return 8'($urandom_range(0, 255));
        end
        if (settle_job || roll < 45)
        begin
            return B_ACK;
        end
        if (roll < 60)
        begin
            case ($urandom_range(0, 2))
                0:       return B_RESEND;
                1:       return B_ERROR;
                default: return B_OVERRUN;
            endcase
        end
        if (roll < 75)
        begin
            case ($urandom_range(0, 2))
                0:       return B_BAT_OK;
                1:       return B_BAT_FAIL1;
                default: return B_BAT_FAIL2;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One job from request to report, with replies, deadline ticks and some noise mixed in.
    // After a dozen steps the replies steer the job to its end.
    task automatic run_random_job();
        int steps;
        int roll;
        int n;
        logic [2:0] act;
        logic [7:0] b;
        steps = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            act = ($urandom_range(0, 1) != 0) ? ACT_TICK : ACT_RX_BYTE;
            send_item(act, 1'($urandom), 8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 2))
            0:       act = ACT_SEND;
            1:       act = ACT_RESET;
            default: act = ACT_IDENTIFY;
        endcase
        b = ($urandom_range(0, 6) == 0) ? B_RESET_CMD : 8'($urandom_range(0, 255));
        send_item(act, 1'($urandom), b);
        while (job_phase != PH_IDLE)
        begin
            steps++;
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                if ($urandom_range(0, 1) != 0)
                    act = 3'($urandom_range(ACT_SEND, ACT_IDENTIFY));
                else
                    act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                send_item(act, 1'($urandom), 8'($urandom_range(0, 255)));
            end
            else if (roll < 30)
            begin
                n = (ticks_left <= 12 && $urandom_range(0, 1) != 0) ? int'(ticks_left)
                                                                    : $urandom_range(1, 3);
                repeat (n) send_item(ACT_TICK, 1'($urandom), 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_item(ACT_RX_BYTE, 1'($urandom), pick_reply(steps > 12));
            end
        end
    endtask

    task automatic test_random_jobs(input int budget, input logic [CFG_BITS-1:0] cmd_t,
                                    input logic [CFG_BITS-1:0] rst_t,
                                    input logic [CFG_BITS-1:0] read_t);
        int first;
        settle();
        load_timeouts(cmd_t, rst_t, read_t);
        first = items_sent;
        while (items_sent - first < budget)
            run_random_job();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling = 1'b1;
        test_command_job();
        test_reset_job();
        test_identify_job();
        test_deadlines();
        test_random_jobs(570, CFG_BITS'(3), CFG_BITS'(5), CFG_BITS'(2));
        test_random_jobs(290, DEADLINE_MAX, DEADLINE_MAX, DEADLINE_MAX);
        test_random_jobs(420, CFG_BITS'($urandom_range(1, 8)),
                         CFG_BITS'($urandom_range(1, 8)), CFG_BITS'($urandom_range(1, 8)));
        settle();
        idling = 1'b0;
        test_random_jobs(420, CFG_BITS'(1), CFG_BITS'(2), CFG_BITS'(1));
        settle();
        $display("Run covered %0d input beats and %0d result beats over %0d timeout settings.",
                 items_sent, results_seen, settings_used);
        $display("Outcomes: acked %0d, timeout %0d, unexpected %0d, reset ok %0d, %s %0d, %s %0d, %s %0d.",
                 outcome_count[ST_ACKED], outcome_count[ST_TIMEOUT],
                 outcome_count[ST_UNEXPECTED], outcome_count[ST_RESET_OK],
                 "reset failed", outcome_count[ST_RESET_FAIL],
                 "type reported", outcome_count[ST_TYPE_OK],
                 "identify failed", outcome_count[ST_ID_FAIL]);
        if (mismatches == 0 && job_reports_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: ps2_command_ack_sequencer.f
rtl/ps2ca_pkg.sv
rtl/ps2ca_step.sv
rtl/ps2_command_ack_sequencer.sv
bench/ps2_command_ack_sequencer_tb.sv
